// File: rtl/fbm_pkg.sv
// Package for the 3x3 filter bank best-match block.
// Holds the field widths, stream packing offsets and the controller state type.
// No dependencies; used by filter_bank_best_match_3x3_top.
package fbm_pkg;

	localparam int TAPS       = 9;
	localparam int TAP_W      = 4;
	localparam int ADDR_W     = 11;
	localparam int COEF_W     = 16;
	localparam int PIX_W      = 8;
	localparam int PROD_W     = PIX_W + 1 + COEF_W;
	localparam int SUM_W      = 28;
	localparam int RESP_W     = 27;
	localparam int OUT_IDX_W  = 7;
	localparam int CFG_W      = 8;

	localparam int ADDR_LSB   = 0;
	localparam int COEF_LSB   = ADDR_LSB + ADDR_W;
	localparam int PIX_LSB    = COEF_LSB + COEF_W;
	localparam int S_DATA_W   = ((PIX_LSB + TAPS * PIX_W + 7) / 8) * 8;
	localparam int M_DATA_W   = ((OUT_IDX_W + RESP_W + 7) / 8) * 8;

	// Reciprocal of nine scaled by 2^16; exact for every 11-bit address.
	localparam int RECIP_SHIFT = 16;
	localparam int RECIP_W     = 13;
	localparam logic [RECIP_W-1:0] RECIP_NINE = 13'd7282;
	localparam int QUO_W       = 8;

	localparam logic [CFG_W-1:0]  CFG_RESET = 8'd128;
	localparam logic [RESP_W-1:0] RESP_MAX  = 27'd75202560;

	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_WINDOW = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LD_DIV,
		ST_LD_WR,
		ST_EV_RUN,
		ST_EV_DRAIN,
		ST_EV_DONE
	} fbm_state_t;

endpackage

// File: rtl/filter_bank_best_match_3x3_top.sv
// A load beat passes through the divide and write states before the next beat is taken; a
// window beat reads each of the clamped count of filters, drains the pipeline and loads m_tdata.
// The nine tap banks deliver one filter's taps per cycle, and only one item is taken at a time.
// A finished result waits in the output register while the next beat is accepted.
// Reset clears the controller, the valid bits and the filter count (128); the taps are
// undefined until loaded.
// Top level of the 3x3 filter bank best-match block; depends on fbm_pkg.
module filter_bank_best_match_3x3_top #(
	parameter int MAX_FILTERS = 128
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [fbm_pkg::CFG_W-1:0]       cfg_wr_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// Fields from bit 0: coef_addr, coef_value, pix_0 .. pix_8, zero padding.
	input  logic [fbm_pkg::S_DATA_W-1:0]    s_tdata,
	// Fields from bit 0: req_type.
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// Fields from bit 0: best_filter, best_response, zero padding.
	output logic [fbm_pkg::M_DATA_W-1:0]    m_tdata
);
	import fbm_pkg::*;

	localparam int FW          = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
	localparam int STORE_DEPTH = MAX_FILTERS * TAPS;

	fbm_state_t state_q, state_d;

	logic [CFG_W-1:0]          fiu_q;
	logic [ADDR_W-1:0]         addr_q;
	logic [COEF_W-1:0]         coef_q;
	logic [PIX_W-1:0]          pix_q [TAPS];
	logic [FW-1:0]             last_idx_q;
	logic [FW-1:0]             last_idx;
	logic [QUO_W-1:0]          quo_q;
	logic [ADDR_W+RECIP_W-1:0] div_prod;
	logic [ADDR_W-1:0]         quo_nine;
	logic [ADDR_W-1:0]         rem;
	logic [TAP_W-1:0]          wr_tap;
	logic [FW-1:0]             wr_row;
	logic                      addr_ok;
	logic                      accept;
	logic                      issue;
	logic                      wr_en;
	logic                      out_load;
	logic [FW-1:0]             rd_idx_q;

	logic [COEF_W-1:0]         coef_mem [TAPS][MAX_FILTERS];
	logic [COEF_W-1:0]         rd_data_s1 [TAPS];
	logic signed [PROD_W-1:0]  prod_s2 [TAPS];
	logic signed [SUM_W-1:0]   part_s3 [3];
	logic signed [SUM_W-1:0]   sum_s4;
	logic [SUM_W-1:0]          neg_s4;
	logic [RESP_W-1:0]         abs_s5;
	logic                      vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic                      last_s1, last_s2, last_s3, last_s4, last_s5;
	logic [FW-1:0]             idx_s1, idx_s2, idx_s3, idx_s4, idx_s5;

	logic [RESP_W-1:0]         best_val_q;
	logic [FW-1:0]             best_idx_q;
	logic                      m_valid_q;
	logic [OUT_IDX_W-1:0]      m_filter_q;
	logic [RESP_W-1:0]         m_resp_q;

	assign accept = s_tvalid && s_tready;

	// Clamp the filter count to 1 .. MAX_FILTERS and keep the last index.
	always_comb begin
		if (fiu_q == '0) begin
			last_idx = '0;
		end else if (32'(fiu_q) > MAX_FILTERS) begin
			last_idx = FW'(MAX_FILTERS - 1);
		end else begin
			last_idx = FW'(fiu_q - 8'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fiu_q <= CFG_RESET;
		end else if (cfg_wr_en) begin
			fiu_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q     <= s_tdata[ADDR_LSB +: ADDR_W];
			coef_q     <= s_tdata[COEF_LSB +: COEF_W];
			last_idx_q <= last_idx;
			for (int k = 0; k < TAPS; k++) begin
				pix_q[k] <= s_tdata[PIX_LSB + k * PIX_W +: PIX_W];
			end
		end
	end

	// Tap address split into filter row and tap lane: address / 9 by reciprocal.
	assign div_prod = (ADDR_W+RECIP_W)'(addr_q) * (ADDR_W+RECIP_W)'(RECIP_NINE);

	always_ff @(posedge clk) begin
		if (state_q == ST_LD_DIV) begin
			quo_q <= div_prod[RECIP_SHIFT +: QUO_W];
		end
	end

	assign quo_nine = {quo_q, 3'b000} + ADDR_W'(quo_q);
	assign rem      = addr_q - quo_nine;
	assign wr_tap   = rem[TAP_W-1:0];
	assign wr_row   = FW'(quo_q);
	assign addr_ok  = 32'(addr_q) < STORE_DEPTH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		issue    = 1'b0;
		wr_en    = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = (s_tuser == REQ_WINDOW) ? ST_EV_RUN : ST_LD_DIV;
				end
			end
			ST_LD_DIV: begin
				state_d = ST_LD_WR;
			end
			ST_LD_WR: begin
				wr_en   = addr_ok;
				state_d = ST_IDLE;
			end
			ST_EV_RUN: begin
				issue = 1'b1;
				if (rd_idx_q == last_idx_q) begin
					state_d = ST_EV_DRAIN;
				end
			end
			ST_EV_DRAIN: begin
				if (vld_s5 && last_s5) begin
					state_d = ST_EV_DONE;
				end
			end
			ST_EV_DONE: begin
				if (!m_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
		end else if (accept) begin
			rd_idx_q <= '0;
		end else if (issue) begin
			rd_idx_q <= rd_idx_q + FW'(1);
		end
	end

	// Nine tap banks, one row per filter; loads and windows never overlap.
	for (genvar k = 0; k < TAPS; k++) begin : g_bank
		always_ff @(posedge clk) begin
			if (wr_en && wr_tap == TAP_W'(k)) begin
				coef_mem[k][wr_row] <= coef_q;
			end
			if (issue) begin
				rd_data_s1[k] <= coef_mem[k][rd_idx_q];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	assign neg_s4 = -sum_s4;

	always_ff @(posedge clk) begin
		last_s1 <= rd_idx_q == last_idx_q;
		idx_s1  <= rd_idx_q;
		last_s2 <= last_s1;
		idx_s2  <= idx_s1;
		last_s3 <= last_s2;
		idx_s3  <= idx_s2;
		last_s4 <= last_s3;
		idx_s4  <= idx_s3;
		last_s5 <= last_s4;
		idx_s5  <= idx_s4;
		for (int k = 0; k < TAPS; k++) begin
			prod_s2[k] <= $signed({1'b0, pix_q[k]}) * $signed(rd_data_s1[k]);
		end
		for (int g = 0; g < 3; g++) begin
			part_s3[g] <= SUM_W'(prod_s2[3*g]) + SUM_W'(prod_s2[3*g+1])
				+ SUM_W'(prod_s2[3*g+2]);
		end
		sum_s4 <= part_s3[0] + part_s3[1] + part_s3[2];
		abs_s5 <= sum_s4[SUM_W-1] ? neg_s4[RESP_W-1:0] : sum_s4[RESP_W-1:0];
	end

	// The first filter seeds the maximum; later ones replace it only when strictly larger.
	always_ff @(posedge clk) begin
		if (vld_s5 && (idx_s5 == '0 || abs_s5 > best_val_q)) begin
			best_val_q <= abs_s5;
			best_idx_q <= idx_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_filter_q <= OUT_IDX_W'(best_idx_q);
			m_resp_q   <= best_val_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = M_DATA_W'({m_resp_q, m_filter_q});

`ifndef SYNTHESIS
	a_resp_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_resp_q <= RESP_MAX)
		else $error("Best response exceeds the largest possible dot product.");

	a_rd_in_eval: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q == ST_EV_RUN || state_q == ST_EV_DRAIN))
		else $error("Tap read beat outside of a window evaluation.");

	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s5 && last_s5) |=> state_q == ST_EV_DONE)
		else $error("Last filter response did not complete the window.");

	a_no_wr_eval: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !vld_s1 && !issue)
		else $error("Tap write overlaps a bank read.");

	a_out_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == ST_EV_DONE)
		else $error("Result beat raised without a finished window.");
`endif

endmodule

// File: bench/filter_bank_best_match_3x3_top_test.sv
// Self-checking bench for filter_bank_best_match_3x3_top: streams tap loads and pixel
// windows, predicts the best-matching filter per window and checks every result beat.
// Depends on fbm_pkg and the RTL top level only.
module filter_bank_best_match_3x3_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import fbm_pkg::*;

	localparam int BANK_FILTERS = 128;
	localparam int BANK_DEPTH = BANK_FILTERS * TAPS;
	localparam int ADDR_TOP = (1 << ADDR_W) - 1;
	localparam int PIX_PAD = S_DATA_W - PIX_LSB - TAPS * PIX_W;
	localparam int RES_PAD = M_DATA_W - OUT_IDX_W - RESP_W;
	localparam int PHASES = 12;
	localparam int PRESSURE_PHASE = 6;
	localparam int HOLD_CYCLES = 1000;
	localparam logic [CFG_W-1:0] COUNT_PLAN [PHASES] = '{
		8'd0, 8'd2, 8'd9, 8'd1, 8'd33, 8'd128, 8'd255, 8'd129, 8'd127, 8'd64, 8'd5, 8'd200
	};
	localparam logic signed [COEF_W-1:0] EDGE_TAPS [TAPS] = '{
		16'sh7fff, 16'sh8000, 16'sh0000, 16'sh0001, 16'shffff,
		16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff
	};

	typedef logic [TAPS-1:0][PIX_W-1:0] window_t;

	typedef struct packed {
		logic [PIX_PAD-1:0] pad;
		window_t pix;
		logic signed [COEF_W-1:0] coef;
		logic [ADDR_W-1:0] addr;
	} req_word_t;

	typedef struct {
		logic kind;
		req_word_t word;
	} request_t;

	typedef struct packed {
		logic [RES_PAD-1:0] pad;
		logic [RESP_W-1:0] resp;
		logic [OUT_IDX_W-1:0] idx;
	} match_t;

	typedef enum int unsigned {
		TAPS_RANDOM, TAPS_COPY, TAPS_NEGATED, TAPS_ZERO, TAPS_EXTREME, TAPS_SMALL
	} tap_style_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_W-1:0] cfg_wr_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic s_tuser = REQ_LOAD;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;

	request_t pending_requests [$];
	match_t expected_matches [$];
	logic signed [COEF_W-1:0] tap_bank [BANK_DEPTH];
	logic [CFG_W-1:0] filter_count = CFG_RESET;
	logic signed [COEF_W-1:0] planned_taps [BANK_DEPTH];
	bit planned_loaded [BANK_DEPTH];
	int unsigned beats_queued = 0;
	int unsigned beats_taken = 0;
	int unsigned mismatches = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned phase_num = 0;
	int unsigned hold_left = 0;
	bit hold_done = 1'b0;

	filter_bank_best_match_3x3_top #(
		.MAX_FILTERS(BANK_FILTERS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic int unsigned clamp_count(logic [CFG_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > BANK_FILTERS)
			return BANK_FILTERS;
		return v;
	endfunction

	function automatic match_t best_match(window_t px);
		match_t m;
		int acc;
		int tap;
		int unsigned mag;
		int unsigned n;
		m = '0;
		n = clamp_count(filter_count);
		for (int f = 0; f < n; f++) begin
			acc = 0;
			for (int t = 0; t < TAPS; t++) begin
				tap = tap_bank[f * TAPS + t];
				acc += int'(px[t]) * tap;
			end
			mag = (acc < 0) ? -acc : acc;
			if (f == 0 || mag > m.resp) begin
				m.idx = OUT_IDX_W'(f);
				m.resp = RESP_W'(mag);
			end
		end
		return m;
	endfunction

	function automatic void accept_request(logic kind, req_word_t w);
		if (kind == REQ_LOAD) begin
			if (w.addr < BANK_DEPTH)
				tap_bank[w.addr] = w.coef;
		end else begin
			expected_matches.push_back(best_match(w.pix));
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		request_t r;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= REQ_LOAD;
		end else begin
			if (s_tvalid && s_tready) begin
				accept_request(s_tuser, req_word_t'(s_tdata));
				beats_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					r = pending_requests.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= r.kind;
					s_tdata <= r.word;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (phase_num == PRESSURE_PHASE && !hold_done) begin
			m_tready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		match_t got;
		match_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = match_t'(m_tdata);
			if (expected_matches.size() == 0) begin
				$display("%0t: unexpected result beat, actual filter %0d response %0d",
					$time, got.idx, got.resp);
				mismatches++;
			end else begin
				want = expected_matches.pop_front();
				if (got.idx !== want.idx) begin
					$display("%0t: best_filter expected %0d actual %0d",
						$time, want.idx, got.idx);
					mismatches++;
				end
				if (got.resp !== want.resp) begin
					$display("%0t: best_response expected %0d actual %0d",
						$time, want.resp, got.resp);
					mismatches++;
				end
				if (got.pad !== want.pad) begin
					$display("%0t: padding expected %0h actual %0h",
						$time, want.pad, got.pad);
					mismatches++;
				end
			end
		end
	end

	function automatic void queue_load(int unsigned addr, logic signed [COEF_W-1:0] value);
		request_t r;
		r.kind = REQ_LOAD;
		r.word = '0;
		r.word.addr = ADDR_W'(addr);
		r.word.coef = value;
		for (int t = 0; t < TAPS; t++)
			r.word.pix[t] = PIX_W'($urandom_range(255));
		if (addr < BANK_DEPTH) begin
			planned_taps[addr] = value;
			planned_loaded[addr] = 1'b1;
		end
		pending_requests.push_back(r);
		beats_queued++;
	endfunction

	function automatic void queue_window(window_t px);
		request_t r;
		r.kind = REQ_WINDOW;
		r.word = '0;
		r.word.addr = ADDR_W'($urandom);
		r.word.coef = COEF_W'($urandom);
		r.word.pix = px;
		pending_requests.push_back(r);
		beats_queued++;
	endfunction

	function automatic void queue_filter(int unsigned f, tap_style_t style);
		int unsigned g;
		logic signed [COEF_W-1:0] v;
		g = (f == 0) ? 0 : $urandom_range(f - 1);
		for (int t = 0; t < TAPS; t++) begin
			case (style)
				TAPS_COPY: v = planned_taps[g * TAPS + t];
				TAPS_NEGATED: v = -planned_taps[g * TAPS + t];
				TAPS_ZERO: v = '0;
				TAPS_EXTREME: v = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
				TAPS_SMALL: v = COEF_W'(int'($urandom_range(600)) - 300);
				default: v = COEF_W'($urandom);
			endcase
			queue_load(f * TAPS + t, v);
		end
	endfunction

	function automatic tap_style_t random_style();
		return tap_style_t'($urandom_range(TAPS_SMALL));
	endfunction

	function automatic window_t random_window();
		window_t px;
		int unsigned shape;
		shape = $urandom_range(9);
		for (int t = 0; t < TAPS; t++) begin
			case (shape)
				0: px[t] = '0;
				1: px[t] = '1;
				2: px[t] = $urandom_range(1) ? 8'hff : 8'h00;
				default: px[t] = PIX_W'($urandom_range(255));
			endcase
		end
		return px;
	endfunction

	task automatic set_filter_count(logic [CFG_W-1:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		filter_count = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic settle(int unsigned tail);
		do
			@(negedge clk);
		while (beats_taken != beats_queued || expected_matches.size() != 0);
		repeat (tail) @(negedge clk);
	endtask

	task automatic set_pace();
		case (phase_num * 3 / (PHASES + 1))
			0: begin
				send_idle_pct = 34;
				recv_idle_pct = 45;
			end
			1: begin
				send_idle_pct = 45;
				recv_idle_pct = 34;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		endcase
	endtask

	task automatic run_phase(logic [CFG_W-1:0] count, int unsigned items);
		int unsigned active;
		int unsigned n;
		int unsigned roll;
		bit missing;
		active = clamp_count(count);
		set_filter_count(count);
		// Taps of every filter in use must be loaded before the first window.
		for (int f = 0; f < active; f++) begin
			missing = 1'b0;
			for (int t = 0; t < TAPS; t++)
				if (!planned_loaded[f * TAPS + t])
					missing = 1'b1;
			if (missing)
				queue_filter(f, random_style());
		end
		n = 0;
		while (n < items) begin
			roll = $urandom_range(99);
			if (roll < 70) begin
				queue_window(random_window());
				n++;
			end else if (roll < 85) begin
				queue_filter($urandom_range(active - 1), random_style());
				n += TAPS;
			end else if (roll < 95) begin
				queue_load($urandom_range(BANK_DEPTH - 1), COEF_W'($urandom));
				n++;
			end else begin
				queue_load($urandom_range(ADDR_TOP, BANK_DEPTH), COEF_W'($urandom));
			end
		end
		settle(16);
	endtask

	initial begin
		window_t px;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		phase_num = 0;
		set_pace();
		set_filter_count(8'd2);
		for (int t = 0; t < TAPS; t++)
			queue_load(t, 16'sh8000);
		for (int t = 0; t < TAPS; t++)
			queue_load(TAPS + t, EDGE_TAPS[t]);
		queue_load(BANK_DEPTH, COEF_W'($urandom));
		queue_load(ADDR_TOP, COEF_W'($urandom));
		queue_window('0);
		queue_window('1);
		for (int t = 0; t < TAPS; t++)
			px[t] = t[0] ? 8'hff : 8'h00;
		queue_window(px);
		for (int t = 0; t < TAPS; t++)
			px[t] = t[0] ? 8'haa : 8'h55;
		queue_window(px);
		queue_window(random_window());
		settle(16);

		for (int p = 0; p < PHASES; p++) begin
			phase_num = p + 1;
			set_pace();
			run_phase(COUNT_PLAN[p], 20);
		end

		settle(2 * (7 + BANK_FILTERS));
		if (mismatches == 0 && expected_matches.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: files.f
rtl/fbm_pkg.sv
rtl/filter_bank_best_match_3x3_top.sv
bench/filter_bank_best_match_3x3_top_test.sv
